// ----- design/was_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// was_pkg
// Shared constants, operation and status codes, and the command and status
// bundles between the weekly alarm table controller and datapath.
// ----------------------------------------------------------------------------
package was_pkg;

    localparam int DAYS      = 7;
    localparam int SLOTS_DEF = 5;
    localparam int HOURS     = 24;
    localparam int MINUTES   = 60;

    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_REMOVE = 3'd1;
    localparam logic [2:0] OP_SET    = 3'd2;
    localparam logic [2:0] OP_CLEAR  = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;
    localparam logic [2:0] OP_FIND   = 3'd5;

    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_BAD      = 3'd1;
    localparam logic [2:0] STAT_DUP      = 3'd2;
    localparam logic [2:0] STAT_NOTFOUND = 3'd3;
    localparam logic [2:0] STAT_FULL     = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic       load;
        logic       rd_en;
        logic [2:0] rd_slot;
        logic       wr_en;
        logic [2:0] wr_slot;
        logic       wr_shift;
        logic       chk_en;
        logic       finish;
        logic [2:0] status;
        logic [2:0] cnt_new;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic       bad;
        logic [2:0] op;
        logic [2:0] slot;
        logic [2:0] cnt;
        logic       hit;
        logic       out_free;
    } sts_t;

endpackage

// ----- design/was_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// was_ctrl
// Sequencer for one table operation: dispatch, slot walk over the day,
// shift-down after a remove, and hand-off of the result beat.
// ----------------------------------------------------------------------------
module was_ctrl #(
    parameter int SLOTS = was_pkg::SLOTS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  was_pkg::sts_t sts,
    output was_pkg::cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_DONE
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] iss_reg, iss_next;
    logic       chk_vld_reg, chk_vld_next;
    logic [2:0] chk_idx_reg, chk_idx_next;
    logic [2:0] j_reg, j_next;
    logic [2:0] res_status_reg, res_status_next;
    logic [2:0] res_cnt_reg, res_cnt_next;

    always_comb
    begin
        state_next      = state_reg;
        iss_next        = iss_reg;
        chk_vld_next    = chk_vld_reg;
        chk_idx_next    = chk_idx_reg;
        j_next          = j_reg;
        res_status_next = res_status_reg;
        res_cnt_next    = res_cnt_reg;
        in_ready        = 1'b0;
        cmd             = '0;
        cmd.status      = res_status_reg;
        cmd.cnt_new     = res_cnt_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                iss_next        = 3'd0;
                chk_vld_next    = 1'b0;
                res_cnt_next    = sts.cnt;
                res_status_next = was_pkg::STAT_OK;
                state_next      = S_DONE;
                if (sts.bad)
                begin
                    res_status_next = was_pkg::STAT_BAD;
                end
                else
                begin
                    unique case (sts.op)
                        was_pkg::OP_ADD, was_pkg::OP_REMOVE, was_pkg::OP_FIND:
                        begin
                            state_next = S_SCAN;
                        end
                        was_pkg::OP_SET:
                        begin
                            cmd.wr_en   = 1'b1;
                            cmd.wr_slot = sts.slot;
                            if (sts.slot >= sts.cnt)
                            begin
                                res_cnt_next = sts.slot + 3'd1;
                            end
                        end
                        was_pkg::OP_CLEAR:
                        begin
                            res_cnt_next = 3'd0;
                        end
                        was_pkg::OP_READ:
                        begin
                            if (sts.slot < sts.cnt)
                            begin
                                cmd.rd_en   = 1'b1;
                                cmd.rd_slot = sts.slot;
                            end
                            else
                            begin
                                res_status_next = was_pkg::STAT_NOTFOUND;
                            end
                        end
                        default:
                        begin
                            res_status_next = was_pkg::STAT_BAD;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // one read issued per cycle, its compare in the cycle after
                cmd.chk_en = chk_vld_reg;
                priority if (sts.op != was_pkg::OP_FIND && sts.hit)
                begin
                    chk_vld_next = 1'b0;
                    if (sts.op == was_pkg::OP_ADD)
                    begin
                        res_status_next = was_pkg::STAT_DUP;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        j_next     = chk_idx_reg;
                        state_next = S_SHIFT_RD;
                    end
                end
                else if (iss_reg >= sts.cnt)
                begin
                    chk_vld_next = 1'b0;
                    state_next   = S_DONE;
                    if (sts.op == was_pkg::OP_ADD)
                    begin
                        if (sts.cnt >= 3'(SLOTS))
                        begin
                            res_status_next = was_pkg::STAT_FULL;
                        end
                        else
                        begin
                            cmd.wr_en    = 1'b1;
                            cmd.wr_slot  = sts.cnt;
                            res_cnt_next = sts.cnt + 3'd1;
                        end
                    end
                    else if (sts.op == was_pkg::OP_REMOVE)
                    begin
                        res_status_next = was_pkg::STAT_NOTFOUND;
                    end
                end
                else
                begin
                    cmd.rd_en    = 1'b1;
                    cmd.rd_slot  = iss_reg;
                    iss_next     = iss_reg + 3'd1;
                    chk_vld_next = 1'b1;
                    chk_idx_next = iss_reg;
                end
            end

            S_SHIFT_RD:
            begin
                if (({1'b0, j_reg} + 4'd1) < {1'b0, sts.cnt})
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_slot = j_reg + 3'd1;
                    state_next  = S_SHIFT_WR;
                end
                else
                begin
                    res_cnt_next = sts.cnt - 3'd1;
                    state_next   = S_DONE;
                end
            end

            S_SHIFT_WR:
            begin
                cmd.wr_en    = 1'b1;
                cmd.wr_shift = 1'b1;
                cmd.wr_slot  = j_reg;
                j_next       = j_reg + 3'd1;
                state_next   = S_SHIFT_RD;
            end

            S_DONE:
            begin
                cmd.finish = sts.out_free;
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            iss_reg        <= 3'd0;
            chk_vld_reg    <= 1'b0;
            chk_idx_reg    <= 3'd0;
            j_reg          <= 3'd0;
            res_status_reg <= was_pkg::STAT_OK;
            res_cnt_reg    <= 3'd0;
        end
        else
        begin
            state_reg      <= state_next;
            iss_reg        <= iss_next;
            chk_vld_reg    <= chk_vld_next;
            chk_idx_reg    <= chk_idx_next;
            j_reg          <= j_next;
            res_status_reg <= res_status_next;
            res_cnt_reg    <= res_cnt_next;
        end
    end

endmodule

// ----- design/was_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// was_dpath
// Point memory with per-entry valid bits, day counts, argument capture,
// match and next-alarm compare, last reported alarm and the result register.
// ----------------------------------------------------------------------------
module was_dpath #(
    parameter int SLOTS = was_pkg::SLOTS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [2:0]    operation,
    input  logic [2:0]    weekday,
    input  logic [2:0]    slot,
    input  logic [4:0]    hour,
    input  logic [5:0]    minute,
    input  was_pkg::cmd_t cmd,
    output was_pkg::sts_t sts,
    input  logic          out_ready,
    output logic          out_valid,
    output logic [2:0]    status,
    output logic [2:0]    entry_count,
    output logic [4:0]    entry_hour,
    output logic [5:0]    entry_minute,
    output logic          alarm_found,
    output logic          alarm_changed,
    output logic          alarm_cancel
);

    localparam int DEPTH = was_pkg::DAYS * SLOTS;
    localparam int AW    = $clog2(DEPTH);

    // captured arguments
    logic [2:0] op_reg, wd_reg, slot_reg;
    logic [4:0] hour_reg;
    logic [5:0] minute_reg;

    logic [2:0]       day_cnt_reg [was_pkg::DAYS];
    logic [10:0]      mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [10:0]      mem_q_reg;
    logic             mem_vld_reg;

    logic        best_vld_reg;
    logic [4:0]  best_h_reg;
    logic [5:0]  best_m_reg;
    logic [10:0] best_t_reg;

    logic [2:0] last_day_reg;
    logic [4:0] last_h_reg;
    logic [5:0] last_m_reg;
    logic       last_act_reg;

    logic       out_vld_reg;
    logic [2:0] out_status_reg, out_count_reg;
    logic [4:0] out_hour_reg;
    logic [5:0] out_minute_reg;
    logic       out_found_reg, out_changed_reg, out_cancel_reg;

    logic [2:0]    day;
    logic          time_ok, slot_ok, bad;
    logic [2:0]    cnt;
    logic [10:0]   rd_pt, wr_data;
    logic [4:0]    rd_h;
    logic [5:0]    rd_m;
    logic [10:0]   now_t, rd_t;
    logic          better, changed, is_find, find_ok, read_ok;
    logic [AW-1:0] rd_addr, wr_addr;

    function automatic logic [AW-1:0] pt_addr(input logic [2:0] d, input logic [2:0] s);
        logic [AW-1:0] a;
        a = AW'(d) * AW'(SLOTS) + AW'(s);
        return a;
    endfunction

    always_comb
    begin
        day     = wd_reg - 3'd1;
        time_ok = (hour_reg < 5'(was_pkg::HOURS)) && (minute_reg < 6'(was_pkg::MINUTES));
        slot_ok = slot_reg < 3'(SLOTS);
        unique case (op_reg)
            was_pkg::OP_ADD, was_pkg::OP_REMOVE, was_pkg::OP_FIND:
                bad = (wd_reg == 3'd0) || !time_ok;
            was_pkg::OP_SET:   bad = (wd_reg == 3'd0) || !time_ok || !slot_ok;
            was_pkg::OP_CLEAR: bad = (wd_reg == 3'd0);
            was_pkg::OP_READ:  bad = (wd_reg == 3'd0) || !slot_ok;
            default:           bad = 1'b1;
        endcase
        cnt = (wd_reg == 3'd0) ? 3'd0 : day_cnt_reg[day];

        // an entry never written reads as zero
        rd_pt = mem_vld_reg ? mem_q_reg : 11'd0;
        rd_h  = rd_pt[4:0];
        rd_m  = rd_pt[10:5];

        now_t  = 11'(hour_reg) * 11'd60 + 11'(minute_reg);
        rd_t   = 11'(rd_h) * 11'd60 + 11'(rd_m);
        better = (rd_t > now_t) && (!best_vld_reg || rd_t < best_t_reg);

        wr_data = cmd.wr_shift ? rd_pt : {minute_reg, hour_reg};
        rd_addr = pt_addr(day, cmd.rd_slot);
        wr_addr = pt_addr(day, cmd.wr_slot);

        is_find = (op_reg == was_pkg::OP_FIND);
        find_ok = !bad && is_find;
        read_ok = !bad && (op_reg == was_pkg::OP_READ) && (cmd.status == was_pkg::STAT_OK);
        changed = best_vld_reg && (!last_act_reg || last_day_reg != wd_reg ||
                  last_h_reg != best_h_reg || last_m_reg != best_m_reg);

        sts.bad      = bad;
        sts.op       = op_reg;
        sts.slot     = slot_reg;
        sts.cnt      = cnt;
        sts.hit      = cmd.chk_en && (rd_h == hour_reg) && (rd_m == minute_reg);
        sts.out_free = !out_vld_reg || out_ready;
    end

    // point memory
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            mem_vld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (cmd.rd_en)
            begin
                mem_vld_reg <= valid_reg[rd_addr];
            end
        end
    end

    // arguments, best candidate and result fields
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= operation;
            wd_reg     <= weekday;
            slot_reg   <= slot;
            hour_reg   <= hour;
            minute_reg <= minute;
        end
        if (cmd.chk_en && better)
        begin
            best_h_reg <= rd_h;
            best_m_reg <= rd_m;
            best_t_reg <= rd_t;
        end
        if (cmd.finish)
        begin
            out_status_reg  <= cmd.status;
            out_count_reg   <= bad ? 3'd0 : cmd.cnt_new;
            out_hour_reg    <= read_ok ? rd_h :
                               (find_ok && best_vld_reg) ? best_h_reg : 5'd0;
            out_minute_reg  <= read_ok ? rd_m :
                               (find_ok && best_vld_reg) ? best_m_reg : 6'd0;
            out_found_reg   <= find_ok && best_vld_reg;
            out_changed_reg <= find_ok && changed;
            out_cancel_reg  <= find_ok && !best_vld_reg && last_act_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < was_pkg::DAYS; d++)
            begin
                day_cnt_reg[d] <= 3'd0;
            end
            best_vld_reg <= 1'b0;
            last_day_reg <= 3'd0;
            last_h_reg   <= 5'd0;
            last_m_reg   <= 6'd0;
            last_act_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                best_vld_reg <= 1'b0;
            end
            else if (cmd.chk_en && better)
            begin
                best_vld_reg <= 1'b1;
            end

            if (cmd.finish)
            begin
                out_vld_reg <= 1'b1;
                if (!bad)
                begin
                    day_cnt_reg[day] <= cmd.cnt_new;
                end
                if (find_ok && changed)
                begin
                    last_day_reg <= wd_reg;
                    last_h_reg   <= best_h_reg;
                    last_m_reg   <= best_m_reg;
                    last_act_reg <= 1'b1;
                end
                else if (find_ok && !best_vld_reg)
                begin
                    last_act_reg <= 1'b0;
                end
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_vld_reg;
    assign status        = out_status_reg;
    assign entry_count   = out_count_reg;
    assign entry_hour    = out_hour_reg;
    assign entry_minute  = out_minute_reg;
    assign alarm_found   = out_found_reg;
    assign alarm_changed = out_changed_reg;
    assign alarm_cancel  = out_cancel_reg;

endmodule

// ----- design/weekly_alarm_schedule_table_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weekly_alarm_schedule_table_top
// Weekly alarm table: per weekday up to SLOTS hour:minute points, with add,
// remove, set, clear, read and find-next operations.
// ----------------------------------------------------------------------------
// Usage
//   One operation enters per beat on the s_axis channel; exactly one result
//   beat leaves on m_axis for each. Operations are handled one at a time.
//   A bad argument, set, clear or read goes straight to the result; add and
//   find-next walk the day's points (at most SLOTS), and remove walks them
//   and then shifts the later points down.
//   The walk reads one point per cycle through the single read port
//   of the point memory; a remove moves each later point with one read and
//   one write. The next operation is accepted at the earliest in the cycle
//   after the result is registered.
//   s_axis_tready rises again the cycle after the result moves into the
//   output register, so the next operation can enter while a result beat is
//   still waiting on m_axis_tready. A held result stalls only the next one.
//   Reset clears the day counts, the point valid bits (every point reads as
//   00:00) and the last reported alarm; no clearing pass is needed.
// ----------------------------------------------------------------------------
module weekly_alarm_schedule_table_top #(
    parameter int SLOTS = was_pkg::SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // operation[2:0], weekday[5:3], slot[8:6], hour[13:9], minute[19:14]
    input  logic [23:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[2:0], entry_count[5:3], entry_hour[10:6], entry_minute[16:11],
    // alarm_found[17], alarm_changed[18], alarm_cancel[19]
    output logic [23:0] m_axis_tdata
);

    was_pkg::cmd_t cmd;
    was_pkg::sts_t sts;

    logic [2:0] status, entry_count;
    logic [4:0] entry_hour;
    logic [5:0] entry_minute;
    logic       alarm_found, alarm_changed, alarm_cancel;

    was_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    was_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .operation     (s_axis_tdata[2:0]),
        .weekday       (s_axis_tdata[5:3]),
        .slot          (s_axis_tdata[8:6]),
        .hour          (s_axis_tdata[13:9]),
        .minute        (s_axis_tdata[19:14]),
        .cmd           (cmd),
        .sts           (sts),
        .out_ready     (m_axis_tready),
        .out_valid     (m_axis_tvalid),
        .status        (status),
        .entry_count   (entry_count),
        .entry_hour    (entry_hour),
        .entry_minute  (entry_minute),
        .alarm_found   (alarm_found),
        .alarm_changed (alarm_changed),
        .alarm_cancel  (alarm_cancel)
    );

    assign m_axis_tdata = {4'd0, alarm_cancel, alarm_changed, alarm_found,
                           entry_minute, entry_hour, entry_count, status};

endmodule

// ----- design/was_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// was_check
// Port-level checks on the result channel of the weekly alarm table,
// attached to the top level by bind.
// ----------------------------------------------------------------------------
module was_check #(
    parameter int SLOTS = was_pkg::SLOTS_DEF
) (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    // a stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // any failure carries no point and no alarm flags
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[2:0] != was_pkg::STAT_OK |-> m_axis_tdata[19:6] == 14'd0)
        else $error("failed operation returned point or alarm data");

    a_found_cancel: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[17] && m_axis_tdata[19]))
        else $error("alarm found and cancelled in one beat");

    a_changed_found: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[18] |-> m_axis_tdata[17])
        else $error("alarm changed without an alarm found");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[5:3] <= 3'(SLOTS))
        else $error("entry count above slot count");

endmodule

bind weekly_alarm_schedule_table_top was_check #(
    .SLOTS (SLOTS)
) u_was_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- verif/weekly_alarm_schedule_table_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weekly_alarm_schedule_table_checker
// Watches both stream channels of the weekly alarm table. It keeps its own
// copy of the day lists and the last reported alarm, works out the reply
// for every accepted operation beat and compares each reply beat with the
// oldest outstanding prediction, field by field.
// ----------------------------------------------------------------------------
module weekly_alarm_schedule_table_checker #(
    parameter int SLOTS = was_pkg::SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    // operation[2:0], weekday[5:3], slot[8:6], hour[13:9], minute[19:14]
    input  logic [23:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[2:0], entry_count[5:3], entry_hour[10:6], entry_minute[16:11],
    // alarm_found[17], alarm_changed[18], alarm_cancel[19]
    input  logic [23:0] m_axis_tdata,
    output int          outstanding,
    output int          fail_count
);
    import was_pkg::*;

    // highest field first so the layout matches the reply beat
    typedef struct packed {
        logic       cancel;
        logic       changed;
        logic       found;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [2:0] count;
        logic [2:0] status;
    } reply_t;

    logic [4:0] pt_hour   [DAYS][SLOTS];
    logic [5:0] pt_minute [DAYS][SLOTS];
    logic [2:0] day_count [DAYS];
    logic [2:0] alarm_day;
    logic [4:0] alarm_hour;
    logic [5:0] alarm_minute;
    logic       alarm_active;

    reply_t     expected_replies[$];
    int         errors;

    function automatic reply_t apply_operation(input logic [2:0] op, input logic [2:0] wd,
                                               input logic [2:0] sl, input logic [4:0] hr,
                                               input logic [5:0] mn);
        reply_t r;
        logic   bad;
        logic   time_ok;
        logic   hit;
        int     day;
        int     cnt;
        int     idx;
        int     now;
        int     t;
        int     best;

        r       = '0;
        time_ok = (hr < HOURS) && (mn < MINUTES);
        case (op)
            OP_ADD, OP_REMOVE, OP_FIND: bad = (wd == 0) || !time_ok;
            OP_SET:                     bad = (wd == 0) || !time_ok || (sl >= SLOTS);
            OP_CLEAR:                   bad = (wd == 0);
            OP_READ:                    bad = (wd == 0) || (sl >= SLOTS);
            default:                    bad = 1'b1;
        endcase

        if (bad)
        begin
            r.status = STAT_BAD;
        end
        else
        begin
            day = int'(wd) - 1;
            cnt = int'(day_count[day]);
            idx = cnt;
            for (int i = cnt - 1; i >= 0; i--)
            begin
                if (pt_hour[day][i] == hr && pt_minute[day][i] == mn)
                    idx = i;
            end
            case (op)
                OP_ADD:
                begin
                    // duplicate wins over a full day
                    if (idx < cnt)
                        r.status = STAT_DUP;
                    else if (cnt >= SLOTS)
                        r.status = STAT_FULL;
                    else
                    begin
                        pt_hour[day][cnt]   = hr;
                        pt_minute[day][cnt] = mn;
                        cnt++;
                    end
                end
                OP_REMOVE:
                begin
                    if (idx >= cnt)
                        r.status = STAT_NOTFOUND;
                    else
                    begin
                        for (int i = idx; i + 1 < cnt; i++)
                        begin
                            pt_hour[day][i]   = pt_hour[day][i + 1];
                            pt_minute[day][i] = pt_minute[day][i + 1];
                        end
                        cnt--;
                    end
                end
                OP_SET:
                begin
                    pt_hour[day][sl]   = hr;
                    pt_minute[day][sl] = mn;
                    if (sl >= cnt)
                        cnt = int'(sl) + 1;
                end
                OP_CLEAR:
                    cnt = 0;
                OP_READ:
                begin
                    if (sl >= cnt)
                        r.status = STAT_NOTFOUND;
                    else
                    begin
                        r.hour   = pt_hour[day][sl];
                        r.minute = pt_minute[day][sl];
                    end
                end
                default:
                begin
                    now  = hr * MINUTES + mn;
                    best = 'hFFFF;
                    hit  = 1'b0;
                    // strict compare keeps the first slot on a tie
                    for (int i = 0; i < cnt; i++)
                    begin
                        t = pt_hour[day][i] * MINUTES + pt_minute[day][i];
                        if (t > now && t - now < best)
                        begin
                            best     = t - now;
                            r.hour   = pt_hour[day][i];
                            r.minute = pt_minute[day][i];
                            hit      = 1'b1;
                        end
                    end
                    r.found = hit;
                    if (hit)
                    begin
                        if (!alarm_active || alarm_day != wd || alarm_hour != r.hour
                            || alarm_minute != r.minute)
                        begin
                            r.changed    = 1'b1;
                            alarm_day    = wd;
                            alarm_hour   = r.hour;
                            alarm_minute = r.minute;
                            alarm_active = 1'b1;
                        end
                    end
                    else if (alarm_active)
                    begin
                        r.cancel     = 1'b1;
                        alarm_active = 1'b0;
                    end
                end
            endcase
            day_count[day] = 3'(cnt);
            r.count        = 3'(cnt);
        end
        return r;
    endfunction

    task automatic check_field(input string field, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        reply_t want;
        reply_t got;

        if (!rst_n)
        begin
            for (int d = 0; d < DAYS; d++)
            begin
                day_count[d] = '0;
                for (int s = 0; s < SLOTS; s++)
                begin
                    pt_hour[d][s]   = '0;
                    pt_minute[d][s] = '0;
                end
            end
            alarm_day    = '0;
            alarm_hour   = '0;
            alarm_minute = '0;
            alarm_active = 1'b0;
            expected_replies.delete();
            errors       = 0;
            outstanding <= 0;
            fail_count  <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[19:0];
                if (expected_replies.size() == 0)
                begin
                    $error("reply beat with no operation outstanding: %h", m_axis_tdata);
                    errors++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("entry_count", want.count, got.count);
                    check_field("entry_hour", want.hour, got.hour);
                    check_field("entry_minute", want.minute, got.minute);
                    check_field("alarm_found", want.found, got.found);
                    check_field("alarm_changed", want.changed, got.changed);
                    check_field("alarm_cancel", want.cancel, got.cancel);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_replies.push_back(apply_operation(s_axis_tdata[2:0],
                    s_axis_tdata[5:3], s_axis_tdata[8:6], s_axis_tdata[13:9],
                    s_axis_tdata[19:14]));
            outstanding <= expected_replies.size();
            fail_count  <= errors;
        end
    end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives operation beats into the weekly alarm table: a directed pass over
// the corner cases, then weighted random traffic with random stalls on both
// channels. The checker beside the block predicts and compares replies.
// ----------------------------------------------------------------------------
module testbench;
    import was_pkg::*;

    localparam int SLOTS       = SLOTS_DEF;
    localparam int NUM_RANDOM  = 1350;
    localparam int IDLE_LIMIT  = 2000;

    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    localparam logic [2:0] NO_DAY    = 3'd0;
    localparam logic [2:0] MONDAY    = 3'd1;
    localparam logic [2:0] WEDNESDAY = 3'd3;
    localparam logic [2:0] SUNDAY    = 3'd7;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;

    logic        calm          = 1'b0;
    int          hold_cycles   = 0;
    int          idle_cycles   = 0;
    int          outstanding;
    int          fail_count;

    always #5 clk = ~clk;

    weekly_alarm_schedule_table_top #(.SLOTS(SLOTS)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    weekly_alarm_schedule_table_checker #(.SLOTS(SLOTS)) scoreboard (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .outstanding   (outstanding),
        .fail_count    (fail_count)
    );

    // reply side back-pressure in bursts
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_cycles > 1)
            hold_cycles <= hold_cycles - 1;
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            m_axis_tready <= 1'b0;
            hold_cycles   <= $urandom_range(1, 7);
        end
        else
        begin
            m_axis_tready <= 1'b1;
            hold_cycles   <= 0;
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_op(input logic [2:0] op, input logic [2:0] wd, input logic [2:0] sl,
                           input logic [4:0] hr, input logic [5:0] mn);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, mn, hr, sl, wd, op};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // stop sending and let every outstanding reply come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic send_random();
        logic [2:0] op;
        logic [2:0] wd;
        logic [2:0] sl;
        logic [4:0] hr;
        logic [5:0] mn;
        int         pick;

        pick = $urandom_range(0, 99);
        if (pick < 30)
            op = OP_ADD;
        else if (pick < 45)
            op = OP_REMOVE;
        else if (pick < 55)
            op = OP_SET;
        else if (pick < 59)
            op = OP_CLEAR;
        else if (pick < 74)
            op = OP_READ;
        else if (pick < 96)
            op = OP_FIND;
        else
            op = $urandom_range(0, 1) ? OP_RSVD7 : OP_RSVD6;

        wd = ($urandom_range(0, 19) == 0) ? NO_DAY : 3'($urandom_range(1, 7));
        sl = ($urandom_range(0, 11) == 0) ? 3'($urandom_range(SLOTS, 7))
                                          : 3'($urandom_range(0, SLOTS - 1));

        // a small pool of times makes duplicates and remove hits common
        pick = $urandom_range(0, 19);
        if (pick == 0)
            hr = 5'($urandom_range(HOURS, 31));
        else if (pick < 11)
            hr = 5'($urandom_range(0, 3) * 7);
        else
            hr = 5'($urandom_range(0, HOURS - 1));
        pick = $urandom_range(0, 19);
        if (pick == 0)
            mn = 6'($urandom_range(MINUTES, 63));
        else if (pick < 11)
            mn = 6'($urandom_range(0, 2) * 29);
        else
            mn = 6'($urandom_range(0, MINUTES - 1));

        send_op(op, wd, sl, hr, mn);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty day, no alarm active yet
        send_op(OP_FIND, MONDAY, 3'd0, 5'd0, 6'd0);
        // fill monday, then a duplicate, a full day, and a duplicate on a full day
        send_op(OP_ADD, MONDAY, 3'd0, 5'd23, 6'd59);
        send_op(OP_ADD, MONDAY, 3'd0, 5'd0, 6'd0);
        send_op(OP_ADD, MONDAY, 3'd0, 5'd0, 6'd0);
        send_op(OP_ADD, MONDAY, 3'd0, 5'd12, 6'd30);
        send_op(OP_ADD, MONDAY, 3'd0, 5'd6, 6'd15);
        send_op(OP_ADD, MONDAY, 3'd0, 5'd18, 6'd45);
        send_op(OP_ADD, MONDAY, 3'd0, 5'd7, 6'd0);
        send_op(OP_ADD, MONDAY, 3'd0, 5'd12, 6'd30);
        // new alarm, same alarm again, then nothing later so it cancels
        send_op(OP_FIND, MONDAY, 3'd0, 5'd0, 6'd0);
        send_op(OP_FIND, MONDAY, 3'd0, 5'd5, 6'd0);
        send_op(OP_FIND, MONDAY, 3'd0, 5'd23, 6'd59);
        // remove shifts later points down; second one misses
        send_op(OP_REMOVE, MONDAY, 3'd0, 5'd0, 6'd0);
        send_op(OP_REMOVE, MONDAY, 3'd0, 5'd0, 6'd0);
        send_op(OP_READ, MONDAY, 3'd0, 5'd0, 6'd0);
        send_op(OP_READ, MONDAY, 3'd4, 5'd0, 6'd0);
        // set past the count leaves the skipped slots as they were
        send_op(OP_SET, SUNDAY, 3'(SLOTS - 1), 5'd23, 6'd0);
        send_op(OP_READ, SUNDAY, 3'd2, 5'd0, 6'd0);
        // equal points, first slot wins
        send_op(OP_SET, WEDNESDAY, 3'd0, 5'd10, 6'd0);
        send_op(OP_SET, WEDNESDAY, 3'd1, 5'd10, 6'd0);
        send_op(OP_FIND, WEDNESDAY, 3'd0, 5'd9, 6'd59);
        send_op(OP_CLEAR, MONDAY, 3'd0, 5'd0, 6'd0);
        // argument errors
        send_op(OP_READ, MONDAY, 3'(SLOTS), 5'd0, 6'd0);
        send_op(OP_ADD, NO_DAY, 3'd0, 5'd1, 6'd1);
        send_op(OP_ADD, MONDAY, 3'd0, 5'd31, 6'd63);
        send_op(OP_FIND, MONDAY, 3'd0, 5'd24, 6'd0);
        send_op(OP_SET, MONDAY, 3'd7, 5'd1, 6'd1);
        send_op(OP_RSVD6, MONDAY, 3'd0, 5'd0, 6'd0);
        send_op(OP_RSVD7, MONDAY, 3'd0, 5'd0, 6'd60);
        send_op(OP_CLEAR, NO_DAY, 3'd0, 5'd0, 6'd0);
        drain();

        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            if (n == NUM_RANDOM / 2)
                drain();
            if (n == NUM_RANDOM - 150)
                calm <= 1'b1;
            send_random();
        end
        drain();
        repeat (40) @(posedge clk);

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
